// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante -> cons");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante => cons");

`endif

// ----- hdl/rpdd_pkg.sv -----
// Shared types and constants of the remote packet differential drive.
`default_nettype none

package rpdd_pkg;

    // Packet framing
    localparam logic [7:0] HDR0 = 8'h5A;
    localparam logic [7:0] HDR1 = 8'hA8;

    // Register widths and reset values
    localparam int PWM_W  = 8;
    localparam int MS_W   = 16;
    localparam int AXIS_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PWM_W-1:0] MAX_PWM_RST    = 8'd30;
    localparam logic [PWM_W-1:0] DEADBAND_RST   = 8'd30;
    localparam logic [MS_W-1:0]  KICK_MS_RST    = 16'd500;
    localparam logic [MS_W-1:0]  TIMEOUT_MS_RST = 16'd100;
    localparam logic [PWM_W-1:0] FULL_DUTY      = 8'd255;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_PWM    = 2'd0,
        CFG_DEADBAND   = 2'd1,
        CFG_KICK_MS    = 2'd2,
        CFG_TIMEOUT_MS = 2'd3
    } cfg_idx_t;

    // Deframer position
    typedef enum logic [2:0] {
        FR_HDR0   = 3'd0,
        FR_HDR1   = 3'd1,
        FR_BUTTON = 3'd2,
        FR_XLO    = 3'd3,
        FR_XHI    = 3'd4,
        FR_YLO    = 3'd5,
        FR_YHI    = 3'd6
    } frame_t;

    // Operation handed from front to back
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_TICK   = 2'd1,
        OP_PACKET = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [AXIS_W-1:0]  x;
        logic [AXIS_W-1:0]  y;
    } op_t;

endpackage

`default_nettype wire

// ----- hdl/rpdd_front.sv -----
// Front end: accepts items, deframes serial bytes and classifies each item.
`default_nettype none

module rpdd_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic           command,
    input  wire logic [7:0]     rx_byte,
    output rpdd_pkg::op_t       push_op
);

    rpdd_pkg::frame_t frame_reg, frame_next;
    logic [7:0] x_lo_reg;
    logic [7:0] x_hi_reg;
    logic [7:0] y_lo_reg;

    // Frame position register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= rpdd_pkg::FR_HDR0;
        end
        else if (accept && !command)
        begin
            frame_reg <= frame_next;
        end
    end

    // Payload bytes; the button byte is not kept
    always_ff @(posedge clk)
    begin
        if (accept && !command)
        begin
            if (frame_reg == rpdd_pkg::FR_XLO)
            begin
                x_lo_reg <= rx_byte;
            end
            if (frame_reg == rpdd_pkg::FR_XHI)
            begin
                x_hi_reg <= rx_byte;
            end
            if (frame_reg == rpdd_pkg::FR_YLO)
            begin
                y_lo_reg <= rx_byte;
            end
        end
    end

    // Next frame position and classification
    always_comb
    begin
        frame_next   = frame_reg;
        push_op.kind = command ? rpdd_pkg::OP_TICK : rpdd_pkg::OP_NONE;
        push_op.x    = {x_hi_reg, x_lo_reg};
        push_op.y    = {rx_byte, y_lo_reg};
        unique case (frame_reg)
            rpdd_pkg::FR_HDR0:
            begin
                if (rx_byte == rpdd_pkg::HDR0)
                begin
                    frame_next = rpdd_pkg::FR_HDR1;
                end
            end
            rpdd_pkg::FR_HDR1:
            begin
                if (rx_byte == rpdd_pkg::HDR1)
                begin
                    frame_next = rpdd_pkg::FR_BUTTON;
                end
            end
            rpdd_pkg::FR_BUTTON: frame_next = rpdd_pkg::FR_XLO;
            rpdd_pkg::FR_XLO:    frame_next = rpdd_pkg::FR_XHI;
            rpdd_pkg::FR_XHI:    frame_next = rpdd_pkg::FR_YLO;
            rpdd_pkg::FR_YLO:    frame_next = rpdd_pkg::FR_YHI;
            rpdd_pkg::FR_YHI:
            begin
                frame_next = rpdd_pkg::FR_HDR0;
                if (!command)
                begin
                    push_op.kind = rpdd_pkg::OP_PACKET;
                end
            end
            default: frame_next = rpdd_pkg::FR_HDR0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/rpdd_fifo.sv -----
// Short queue of classified operations between front and back.
`default_nettype none

module rpdd_fifo #(
    parameter int DEPTH = rpdd_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire rpdd_pkg::op_t  push_op,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output rpdd_pkg::op_t       pop_op
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rpdd_pkg::op_t  mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_op    = mem_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rpdd_back.sv -----
// Back end: motor state, mixing, start kick, link timeout and result register.
`default_nettype none

module rpdd_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration writes
    input  wire logic                               cfg_we,
    input  wire logic [rpdd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rpdd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // queue side
    input  wire logic                               op_valid,
    input  wire rpdd_pkg::op_t                      op,
    output logic                                    op_pop,
    // result side
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [7:0]                              left_duty,
    output logic [7:0]                              right_duty,
    output logic                                    left_forward,
    output logic                                    right_forward,
    output logic                                    link_ok,
    output logic                                    packet_done
);

    localparam int PW = rpdd_pkg::PWM_W;
    localparam int MW = rpdd_pkg::MS_W;
    localparam int AW = rpdd_pkg::AXIS_W;

    // Configuration registers
    logic [PW-1:0] max_pwm_reg, deadband_reg;
    logic [MW-1:0] kick_ms_reg, timeout_ms_reg;

    // Motor state; it is also the result payload
    logic [PW-1:0] left_pwm_reg,  left_pwm_next;
    logic [PW-1:0] right_pwm_reg, right_pwm_next;
    logic          left_dir_reg,  left_dir_next;
    logic          right_dir_reg, right_dir_next;
    logic          link_reg,      link_next;
    logic [MW-1:0] since_reg,     since_next;
    logic          lkick_on_reg,  lkick_on_next;
    logic [MW-1:0] lkick_age_reg, lkick_age_next;
    logic          rkick_on_reg,  rkick_on_next;
    logic [MW-1:0] rkick_age_reg, rkick_age_next;
    logic          done_reg,      done_next;
    logic          out_valid_reg, out_valid_next;

    // Mixer terms
    logic [AW-1:0] left_raw, right_raw;
    logic [PW-1:0] left_new, right_new;
    logic          centered;

    function automatic logic [AW:0] mag(input logic [AW-1:0] v);
        logic [AW:0] ext;
        ext = {v[AW-1], v};
        return v[AW-1] ? ((AW+1)'(0) - ext) : ext;
    endfunction

    function automatic logic [MW-1:0] sat_inc(input logic [MW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // min(|raw|,255) * max_pwm / 255, the divide as (p + p/256 + 1) / 256
    function automatic logic [PW-1:0] scale_duty(input logic [AW-1:0] raw,
                                                 input logic [PW-1:0] scale);
        logic [AW:0]      m;
        logic [PW-1:0]    m8;
        logic [2*PW-1:0]  prod;
        logic [2*PW:0]    sum;
        m    = mag(raw);
        m8   = (m > (AW+1)'(255)) ? '1 : m[PW-1:0];
        prod = (2*PW)'(m8) * (2*PW)'(scale);
        sum  = (2*PW+1)'(prod) + (2*PW+1)'(prod[2*PW-1:PW]) + (2*PW+1)'(1);
        return sum[2*PW-1:PW];
    endfunction

    assign op_pop = op_valid && (!out_valid_reg || out_ready);

    // Configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pwm_reg    <= rpdd_pkg::MAX_PWM_RST;
            deadband_reg   <= rpdd_pkg::DEADBAND_RST;
            kick_ms_reg    <= rpdd_pkg::KICK_MS_RST;
            timeout_ms_reg <= rpdd_pkg::TIMEOUT_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rpdd_pkg::CFG_MAX_PWM:    max_pwm_reg    <= cfg_data[PW-1:0];
                rpdd_pkg::CFG_DEADBAND:   deadband_reg   <= cfg_data[PW-1:0];
                rpdd_pkg::CFG_KICK_MS:    kick_ms_reg    <= cfg_data[MW-1:0];
                rpdd_pkg::CFG_TIMEOUT_MS: timeout_ms_reg <= cfg_data[MW-1:0];
                default: ;
            endcase
        end
    end

    // Arcade mix of the packet axes
    assign left_raw  = op.y + op.x;
    assign right_raw = op.x - op.y;
    assign left_new  = scale_duty(left_raw, max_pwm_reg);
    assign right_new = scale_duty(right_raw, max_pwm_reg);
    assign centered  = (mag(op.x) < (AW+1)'(deadband_reg))
                    && (mag(op.y) < (AW+1)'(deadband_reg));

    // Operation, then kick checks, then timeout
    always_comb
    begin
        left_pwm_next  = left_pwm_reg;
        right_pwm_next = right_pwm_reg;
        left_dir_next  = left_dir_reg;
        right_dir_next = right_dir_reg;
        link_next      = link_reg;
        since_next     = since_reg;
        lkick_on_next  = lkick_on_reg;
        lkick_age_next = lkick_age_reg;
        rkick_on_next  = rkick_on_reg;
        rkick_age_next = rkick_age_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (op_pop)
        begin
            out_valid_next = 1'b1;
            done_next      = (op.kind == rpdd_pkg::OP_PACKET);
            unique case (op.kind)
                rpdd_pkg::OP_TICK:
                begin
                    since_next     = sat_inc(since_reg);
                    lkick_age_next = sat_inc(lkick_age_reg);
                    rkick_age_next = sat_inc(rkick_age_reg);
                end
                rpdd_pkg::OP_PACKET:
                begin
                    link_next  = 1'b1;
                    since_next = '0;
                    if (centered)
                    begin
                        left_pwm_next  = '0;
                        right_pwm_next = '0;
                    end
                    else
                    begin
                        left_dir_next  = !left_raw[AW-1] && (left_raw != '0);
                        right_dir_next = !right_raw[AW-1] && (right_raw != '0);
                        if ((left_pwm_reg == '0) && (left_new != '0))
                        begin
                            lkick_on_next  = 1'b1;
                            lkick_age_next = '0;
                        end
                        if ((right_pwm_reg == '0) && (right_new != '0))
                        begin
                            rkick_on_next  = 1'b1;
                            rkick_age_next = '0;
                        end
                        left_pwm_next  = left_new;
                        right_pwm_next = right_new;
                    end
                end
                default: ;
            endcase

            // start kick
            if (lkick_on_next)
            begin
                if ((left_pwm_next != '0) && (lkick_age_next < kick_ms_reg))
                begin
                    left_pwm_next = rpdd_pkg::FULL_DUTY;
                end
                else
                begin
                    lkick_on_next = 1'b0;
                end
            end
            if (rkick_on_next)
            begin
                if ((right_pwm_next != '0) && (rkick_age_next < kick_ms_reg))
                begin
                    right_pwm_next = rpdd_pkg::FULL_DUTY;
                end
                else
                begin
                    rkick_on_next = 1'b0;
                end
            end

            // link timeout
            if (since_next > timeout_ms_reg)
            begin
                left_pwm_next  = '0;
                right_pwm_next = '0;
                link_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_pwm_reg  <= '0;
            right_pwm_reg <= '0;
            left_dir_reg  <= 1'b0;
            right_dir_reg <= 1'b0;
            link_reg      <= 1'b0;
            since_reg     <= '0;
            lkick_on_reg  <= 1'b0;
            lkick_age_reg <= '0;
            rkick_on_reg  <= 1'b0;
            rkick_age_reg <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_pwm_reg  <= left_pwm_next;
            right_pwm_reg <= right_pwm_next;
            left_dir_reg  <= left_dir_next;
            right_dir_reg <= right_dir_next;
            link_reg      <= link_next;
            since_reg     <= since_next;
            lkick_on_reg  <= lkick_on_next;
            lkick_age_reg <= lkick_age_next;
            rkick_on_reg  <= rkick_on_next;
            rkick_age_reg <= rkick_age_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_duty     = left_pwm_reg;
    assign right_duty    = right_pwm_reg;
    assign left_forward  = left_dir_reg;
    assign right_forward = right_dir_reg;
    assign link_ok       = link_reg;
    assign packet_done   = done_reg;

endmodule

`default_nettype wire

// ----- hdl/remote_packet_differential_drive_unit.sv -----
// Remote packet differential drive: serial packet deframer and arcade mixer with
// start kick and link timeout. Each input transaction is a received byte or a
// millisecond tick and yields exactly one result transaction with the current
// motor duties, directions, link flag and a packet-done mark. One transaction is
// accepted per clock while in_ready is high. The front end classifies a transaction
// combinationally and it is written into the queue at its accepting edge; the back
// end pops it from the queue and does the mix, kick and timeout update into the
// result register, which drives out_valid. The queue of QUEUE_DEPTH entries
// between front and back holds transactions while a result waits on out_ready;
// in_ready drops only once it is full.
// Configuration writes are always accepted and are meant for idle periods.
`default_nettype none

module remote_packet_differential_drive_unit #(
    parameter int QUEUE_DEPTH = rpdd_pkg::QUEUE_DEPTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rpdd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rpdd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               command,
    input  wire logic [7:0]                         rx_byte,
    // results
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [7:0]                              left_duty,
    output logic [7:0]                              right_duty,
    output logic                                    left_forward,
    output logic                                    right_forward,
    output logic                                    link_ok,
    output logic                                    packet_done
);

    logic          in_accept;
    logic          q_full;
    logic          q_not_empty;
    logic          q_pop;
    rpdd_pkg::op_t push_op;
    rpdd_pkg::op_t pop_op;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign in_accept = in_valid && in_ready;

    rpdd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .command (command),
        .rx_byte (rx_byte),
        .push_op (push_op)
    );

    rpdd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_op   (push_op),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_op    (pop_op)
    );

    rpdd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .op_valid      (q_not_empty),
        .op            (pop_op),
        .op_pop        (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_duty     (left_duty),
        .right_duty    (right_duty),
        .left_forward  (left_forward),
        .right_forward (right_forward),
        .link_ok       (link_ok),
        .packet_done   (packet_done)
    );

endmodule

`default_nettype wire

// ----- hdl/rpdd_checker.sv -----
// Port-level checker of the drive unit and its bind.
`default_nettype none
`include "assert_macros.svh"

module rpdd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] left_duty,
    input wire logic [7:0] right_duty,
    input wire logic       link_ok,
    input wire logic       packet_done
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(left_duty) && $stable(right_duty))
    `ASSERT_IMPLIES(a_nolink_idle, clk, rst_n, out_valid && !link_ok, left_duty == 8'd0 && right_duty == 8'd0)
    `ASSERT_IMPLIES(a_packet_link, clk, rst_n, out_valid && packet_done, link_ok)

endmodule

bind remote_packet_differential_drive_unit rpdd_checker u_rpdd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_duty   (left_duty),
    .right_duty  (right_duty),
    .link_ok     (link_ok),
    .packet_done (packet_done)
);

`default_nettype wire
